### hdl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the digit character table for the integer to
// ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Width of the value field on the input channel
  localparam int unsigned VALUE_BITS = 32;
  // Character and digit widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned NIB_W  = 4;
  // Double-dabble steps done in one pipeline stage
  localparam int unsigned STEPS_PER_STAGE = 4;

  // Conversion select
  typedef enum logic {
    OP_DEC = 1'b0,
    OP_HEX = 1'b1
  } op_e;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [NIB_W-1:0]  nib_t;

  localparam char_t CHAR_MINUS = 8'h2d;

  // Lowercase hex digit characters
  localparam char_t DIGIT_TABLE [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  function automatic char_t digit_char(input nib_t d);
    return DIGIT_TABLE[d];
  endfunction

endpackage

### hdl/itoa_if.sv
// ----------------------------------------------------------------------------
// itoa_in_if / itoa_out_if
// Valid/ready channels: number words in, character words out.
// ----------------------------------------------------------------------------
interface itoa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        operation;

  modport source (output valid, output value, output operation, input ready);
  modport sink   (input valid, input value, input operation, output ready);
endinterface

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

### hdl/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front
// Two stages: capture and sign detect, then magnitude by negation.
// ----------------------------------------------------------------------------
module itoa_front #(
  parameter int unsigned VW = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [itoa_pkg::VALUE_BITS-1:0] value_i,
  input  logic                            operation_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [VW-1:0]                   mag_o,
  output logic                            hex_o,
  output logic                            neg_o
);
  import itoa_pkg::*;

  localparam int unsigned IN_W = (VW < VALUE_BITS) ? VW : VALUE_BITS;

  logic [VW-1:0] ext;
  logic          hex_in;

  logic          v1_q;
  logic [VW-1:0] val1_q;
  logic          hex1_q, neg1_q;
  logic          rdy1;

  logic          v2_q;
  logic [VW-1:0] mag2_q;
  logic          hex2_q, neg2_q;
  logic          rdy2;

  // Mask or zero-extend the input word to the working width
  always_comb begin
    ext = '0;
    ext[IN_W-1:0] = value_i[IN_W-1:0];
  end
  assign hex_in = (operation_i == OP_HEX);

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // Stage 1: capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      val1_q <= ext;
      hex1_q <= hex_in;
      neg1_q <= !hex_in && ext[VW-1];
    end
  end

  // Stage 2: magnitude, two's complement negate for negative decimals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      mag2_q <= neg1_q ? (~val1_q + {{(VW-1){1'b0}}, 1'b1}) : val1_q;
      hex2_q <= hex1_q;
      neg2_q <= neg1_q;
    end
  end

  assign valid_o = v2_q;
  assign mag_o   = mag2_q;
  assign hex_o   = hex2_q;
  assign neg_o   = neg2_q;

endmodule

### hdl/itoa_dabble.sv
// ----------------------------------------------------------------------------
// itoa_dabble
// One pipeline stage of binary to BCD conversion (shift and add-3).
// Hex words pass through untouched.
// ----------------------------------------------------------------------------
module itoa_dabble #(
  parameter int unsigned VW    = 32,
  parameter int unsigned ND    = 10,
  parameter int unsigned STEPS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [VW-1:0]        bin_i,
  input  logic [ND*4-1:0]      bcd_i,
  input  logic                 hex_i,
  input  logic                 neg_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [VW-1:0]        bin_o,
  output logic [ND*4-1:0]      bcd_o,
  output logic                 hex_o,
  output logic                 neg_o
);
  import itoa_pkg::*;

  localparam int unsigned DW = ND * NIB_W;

  logic          v_q;
  logic [VW-1:0] bin_q, bin_d;
  logic [DW-1:0] bcd_q, bcd_d;
  logic          hex_q, neg_q;

  // STEPS shift/add-3 iterations
  always_comb begin
    logic [VW-1:0] b;
    logic [DW-1:0] m;
    b = bin_i;
    m = bcd_i;
    if (!hex_i) begin
      for (int s = 0; s < STEPS; s++) begin
        for (int k = 0; k < ND; k++) begin
          if (m[k*NIB_W +: NIB_W] >= 4'd5) begin
            m[k*NIB_W +: NIB_W] = m[k*NIB_W +: NIB_W] + 4'd3;
          end
        end
        m = {m[DW-2:0], b[VW-1]};
        b = {b[VW-2:0], 1'b0};
      end
    end
    bin_d = b;
    bcd_d = m;
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
      hex_q <= hex_i;
      neg_q <= neg_i;
    end
  end

  assign valid_o = v_q;
  assign bin_o   = bin_q;
  assign bcd_o   = bcd_q;
  assign hex_o   = hex_q;
  assign neg_o   = neg_q;

endmodule

### hdl/itoa_digits.sv
// ----------------------------------------------------------------------------
// itoa_digits
// Picks decimal or hex digits and finds the most significant nonzero one.
// ----------------------------------------------------------------------------
module itoa_digits #(
  parameter int unsigned VW = 32,
  parameter int unsigned ND = 10,
  parameter int unsigned PW = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [VW-1:0]      bin_i,
  input  logic [ND*4-1:0]    bcd_i,
  input  logic               hex_i,
  input  logic               neg_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [ND*4-1:0]    dig_o,
  output logic [PW-1:0]      top_o,
  output logic               neg_o
);
  import itoa_pkg::*;

  localparam int unsigned DW = ND * NIB_W;

  logic          v_q;
  logic [DW-1:0] dig_q, dig_d;
  logic [PW-1:0] top_q, top_d;
  logic          neg_q;

  // Digit source and leading digit index (zero gives index 0)
  always_comb begin
    dig_d = hex_i ? {{(DW-VW){1'b0}}, bin_i} : bcd_i;
    top_d = '0;
    for (int k = 1; k < ND; k++) begin
      if (dig_d[k*NIB_W +: NIB_W] != '0) begin
        top_d = PW'(k);
      end
    end
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dig_q <= dig_d;
      top_q <= top_d;
      neg_q <= neg_i;
    end
  end

  assign valid_o = v_q;
  assign dig_o   = dig_q;
  assign top_o   = top_q;
  assign neg_o   = neg_q;

endmodule

### hdl/itoa_serial.sv
// ----------------------------------------------------------------------------
// itoa_serial
// Emits sign and digits of one number, one character word a cycle if ready.
// ----------------------------------------------------------------------------
module itoa_serial #(
  parameter int unsigned ND = 10,
  parameter int unsigned PW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [ND*4-1:0] dig_i,
  input  logic [PW-1:0]   top_i,
  input  logic            neg_i,
  itoa_out_if.source      out_o
);
  import itoa_pkg::*;

  logic          busy_q;
  logic          sign_q;
  logic [PW-1:0] pos_q;
  nib_t          dig_q [ND];
  logic          last;
  logic          take;
  logic          load;

  assign last    = !sign_q && (pos_q == '0);
  assign take    = busy_q && out_o.ready;
  assign ready_o = !busy_q || (out_o.ready && last);
  assign load    = valid_i && ready_o;

  // Control: busy flag, pending sign, current digit position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      pos_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      sign_q <= neg_i;
      pos_q  <= top_i;
    end else if (take) begin
      if (sign_q) begin
        sign_q <= 1'b0;
      end else if (pos_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        pos_q <= pos_q - PW'(1);
      end
    end
  end

  // Digit hold register
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < ND; k++) begin
        dig_q[k] <= dig_i[k*NIB_W +: NIB_W];
      end
    end
  end

  assign out_o.valid      = busy_q;
  assign out_o.ascii_char = sign_q ? CHAR_MINUS : digit_char(dig_q[pos_q]);
  assign out_o.last       = last;

endmodule

### hdl/integer_to_ascii_digits_top.sv
// Path: front capture and magnitude stages, shift/add-3 pipeline (four bits
// per stage), digit select stage, then the character serializer.
// Throughput: one character word per cycle while out_o.ready is high; the
// serializer loads the next number as the last character of one is taken.
// Reset: rst_ni asynchronous, active low; clears all valid and busy flags.
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_top
// Signed decimal or lowercase hex conversion to ASCII characters, most
// significant first, no leading zeros, last character flagged.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  itoa_in_if.sink   in_i,
  itoa_out_if.source out_o
);
  import itoa_pkg::*;

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned ND  = ((VW * 1233) >> 12) + 1;
  localparam int unsigned DW  = ND * NIB_W;
  localparam int unsigned PW  = $clog2(ND);
  localparam int unsigned NST = (VW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Chain of pipeline links: index 0 is the front, NST the last dabble stage
  logic          lv   [NST+1];
  logic          lr   [NST+1];
  logic [VW-1:0] lbin [NST+1];
  logic [DW-1:0] lbcd [NST+1];
  logic          lhex [NST+1];
  logic          lneg [NST+1];

  logic          dv, dr;
  logic [DW-1:0] ddig;
  logic [PW-1:0] dtop;
  logic          dneg;

  // Sign detect and magnitude
  itoa_front #(.VW(VW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .value_i     (in_i.value),
    .operation_i (in_i.operation),
    .valid_o     (lv[0]),
    .ready_i     (lr[0]),
    .mag_o       (lbin[0]),
    .hex_o       (lhex[0]),
    .neg_o       (lneg[0])
  );
  assign lbcd[0] = '0;

  // Binary to BCD stages
  for (genvar g = 0; g < NST; g++) begin : g_dabble
    localparam int unsigned REM = VW - g * STEPS_PER_STAGE;
    localparam int unsigned ST  = (REM < STEPS_PER_STAGE) ? REM : STEPS_PER_STAGE;
    itoa_dabble #(.VW(VW), .ND(ND), .STEPS(ST)) u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lv[g]),
      .ready_o (lr[g]),
      .bin_i   (lbin[g]),
      .bcd_i   (lbcd[g]),
      .hex_i   (lhex[g]),
      .neg_i   (lneg[g]),
      .valid_o (lv[g+1]),
      .ready_i (lr[g+1]),
      .bin_o   (lbin[g+1]),
      .bcd_o   (lbcd[g+1]),
      .hex_o   (lhex[g+1]),
      .neg_o   (lneg[g+1])
    );
  end

  // Digit select and leading digit search
  itoa_digits #(.VW(VW), .ND(ND), .PW(PW)) u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lv[NST]),
    .ready_o (lr[NST]),
    .bin_i   (lbin[NST]),
    .bcd_i   (lbcd[NST]),
    .hex_i   (lhex[NST]),
    .neg_i   (lneg[NST]),
    .valid_o (dv),
    .ready_i (dr),
    .dig_o   (ddig),
    .top_o   (dtop),
    .neg_o   (dneg)
  );

  // Character output
  itoa_serial #(.ND(ND), .PW(PW)) u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv),
    .ready_o (dr),
    .dig_i   (ddig),
    .top_i   (dtop),
    .neg_i   (dneg),
    .out_o   (out_o)
  );

endmodule
